@@ hw/rtl/bcfe_pkg.sv @@
// Shared types, codes and encoder functions for the LE Coded PHY FEC encoder.
// No dependencies; imported by the front, back and top level modules.
package bcfe_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_TERM = 1'b1;
  localparam logic BLK_ONE  = 1'b0;
  localparam logic BLK_TWO  = 1'b1;

  localparam logic [7:0] PAT_00 = 8'h33;
  localparam logic [7:0] PAT_01 = 8'hc3;
  localparam logic [7:0] PAT_10 = 8'h3c;
  localparam logic [7:0] PAT_11 = 8'hcc;

  localparam logic [3:0] DATA_BITS  = 4'd8;
  localparam logic [3:0] TERM1_BITS = 4'd5;
  localparam logic [3:0] TERM2_S8_BITS = 4'd3;
  localparam logic [3:0] TERM2_S2_BITS = 4'd4;
  localparam logic [3:0] S2_STEP = 4'd4;
  localparam logic [3:0] S8_STEP = 4'd1;

  typedef struct packed {
    logic       s2;
    logic [7:0] bits;
    logic [3:0] count;
  } job_t;

  function automatic logic [7:0] s8_map(input logic [1:0] a);
    logic [7:0] r;
    unique case (a)
      2'b00:   r = PAT_00;
      2'b01:   r = PAT_01;
      2'b10:   r = PAT_10;
      default: r = PAT_11;
    endcase
    return r;
  endfunction

  // {next state, g1, g0}
  function automatic logic [4:0] conv_step(input logic [2:0] st, input logic b);
    logic g0;
    logic g1;
    g0 = b ^ st[0] ^ st[1] ^ st[2];
    g1 = b ^ st[1] ^ st[2];
    return {st[1:0], b, g1, g0};
  endfunction

endpackage

@@ hw/rtl/bcfe_front.sv @@
// Front end: accepts requests, classifies them into encoder jobs and queues them.
// Depends on bcfe_pkg.
module bcfe_front #(
  parameter int unsigned QUEUE_DEPTH = bcfe_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  input  logic              block_sel,
  input  logic [1:0]        coding_indicator,
  input  logic              second_block_s8,
  output logic              job_valid,
  input  logic              job_pop,
  output bcfe_pkg::job_t    job
);
  import bcfe_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  job_t           q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  job_t           new_job;
  logic           push;

  always_comb begin
    new_job = '0;
    if (cmd == CMD_TERM) begin
      if (block_sel == BLK_ONE) begin
        new_job.bits  = {coding_indicator, 6'b0};
        new_job.count = TERM1_BITS;
      end else if (second_block_s8) begin
        new_job.count = TERM2_S8_BITS;
      end else begin
        new_job.s2    = 1'b1;
        new_job.count = TERM2_S2_BITS;
      end
    end else begin
      new_job.s2    = (block_sel == BLK_TWO) && !second_block_s8;
      new_job.bits  = data_byte;
      new_job.count = DATA_BITS;
    end
  end

  assign in_ready  = (fill != CntFull);
  assign push      = in_valid && in_ready;
  assign job_valid = (fill != '0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !job_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && job_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/bcfe_back.sv @@
// Back end: runs the K=4 convolutional encoder over queued jobs and maps the
// coded bits to S8 patterns or packed S2 symbols. Depends on bcfe_pkg.
module bcfe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_pop,
  input  bcfe_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last
);
  import bcfe_pkg::*;

  logic       busy;
  logic       s2;
  logic [7:0] bits;
  logic [3:0] rem;
  logic [2:0] enc;

  logic       adv;
  logic       last_step;
  logic [4:0] r8;
  logic [2:0] st2;
  logic [4:0] r2;
  logic [7:0] pk;
  logic [7:0] byte_next;
  logic [2:0] enc_next;
  logic [3:0] step;

  always_comb begin
    r8  = conv_step(enc, bits[7]);
    st2 = enc;
    pk  = '0;
    r2  = '0;
    for (int i = 0; i < 4; i++) begin
      r2  = conv_step(st2, bits[7-i]);
      pk  = {pk[5:0], r2[0], r2[1]};
      st2 = r2[4:2];
    end
  end

  assign step      = s2 ? S2_STEP : S8_STEP;
  assign last_step = (rem <= step);
  assign byte_next = s2 ? pk : s8_map(r8[1:0]);
  assign enc_next  = s2 ? st2 : r8[4:2];
  assign adv       = busy && (!out_valid || out_ready);
  assign job_pop   = job_valid && (!busy || (adv && last_step));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= byte_next;
      last     <= last_step;
    end
    if (job_pop) begin
      s2   <= job.s2;
      bits <= job.bits;
      rem  <= job.count;
    end else if (adv) begin
      bits <= s2 ? {bits[3:0], 4'b0} : {bits[6:0], 1'b0};
      rem  <= rem - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      enc       <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        enc       <= enc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        busy <= 1'b1;
      end else if (adv && last_step) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ble_coded_phy_fec_encoder_unit.sv @@
// LE Coded PHY FEC encoder top level: APB register, front end queue and encoder back end.
// Depends on bcfe_pkg, bcfe_front and bcfe_back.
//
// Each request is classified and queued on arrival; the back end emits one output byte per
// cycle from its output register while out_ready is high, so a data request gives 8 bytes
// in S8 and 2 in S2, a block 1 terminate 5, a block 2 terminate 3 (S8) or 1 (S2). Requests
// enter the queue back to back while it has room and earlier ones are still being encoded.
// Write second_block_s8 at byte address 0 while idle.
module ble_coded_phy_fec_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = bcfe_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        block_sel,
  input  logic [1:0]  coding_indicator,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcfe_pkg::*;

  logic second_block_s8;
  logic job_valid;
  logic job_pop;
  job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, second_block_s8} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_block_s8 <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      second_block_s8 <= pwdata[0];
    end
  end

  bcfe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .data_byte       (data_byte),
    .block_sel       (block_sel),
    .coding_indicator(coding_indicator),
    .second_block_s8 (second_block_s8),
    .job_valid       (job_valid),
    .job_pop         (job_pop),
    .job             (job)
  );

  bcfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .job      (job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule

@@ hw/rtl/bcfe_checker.sv @@
// Port-level checks for the FEC encoder top level, attached by bind.
// Depends on ble_coded_phy_fec_encoder_unit port names only.
module bcfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last,
  input logic        pready,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output request changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_prdata: assert property (@(posedge clk) prdata[31:1] == 31'b0)
    else $error("register read returned stray bits");

endmodule

bind ble_coded_phy_fec_encoder_unit bcfe_checker u_bcfe_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .last     (last),
  .pready   (pready),
  .prdata   (prdata)
);
